### src/assert_macros.svh
// Assertion macros for the RTL of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every rising edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");
// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");
`else
`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

### src/spm_pkg.sv
// Constants and types of the sparse polynomial multiplier.
package spm_pkg;

   localparam int MAX_TERMS_FIRST  = 8;
   localparam int MAX_TERMS_SECOND = 8;
   localparam int EXPONENT_BITS    = 8;

   localparam int ACTION_W    = 2;
   localparam int COEF_W      = 16;
   localparam int EXP_W       = 8;
   localparam int PROD_COEF_W = 38;
   localparam int PROD_EXP_W  = EXP_W + 1;
   localparam int MUL_W       = 2 * COEF_W;

   localparam int IDX1_W = (MAX_TERMS_FIRST > 1) ? $clog2(MAX_TERMS_FIRST) : 1;
   localparam int IDX2_W = (MAX_TERMS_SECOND > 1) ? $clog2(MAX_TERMS_SECOND) : 1;
   localparam int CNT1_W = $clog2(MAX_TERMS_FIRST + 1);
   localparam int CNT2_W = $clog2(MAX_TERMS_SECOND + 1);

   // Threshold is one bit wider than an exponent sum so that it can sit above all of them.
   localparam int THR_W = PROD_EXP_W + 1;
   localparam logic [THR_W-1:0] THR_ABOVE_ALL = THR_W'(1) << PROD_EXP_W;

   localparam logic [EXP_W-1:0] EXP_KEEP_MASK =
      (EXPONENT_BITS >= EXP_W) ? {EXP_W{1'b1}} : EXP_W'((1 << EXPONENT_BITS) - 1);

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD_FIRST  = 2'd0,
      ACT_LOAD_SECOND = 2'd1,
      ACT_COMPUTE     = 2'd2,
      ACT_CLEAR       = 2'd3
   } action_type;

endpackage

### src/sparse_polynomial_multiplier.sv
// Top level of the sparse polynomial multiplier: term stores, scan sequencer and output register.
//
// Usage. Items arrive on the req_ channel (valid/ready). An action of load-first or load-second
// appends the term (req_coefficient, req_exponent) to that store, at most eight terms each; a
// load into a full store is dropped. A clear empties both stores. Loads and clears produce no
// transfer on the rsp_ channel.
// A compute item produces the merged product terms on the rsp_ channel, one transfer per
// distinct exponent, in strictly descending exponent order, with rsp_last set on the final
// one. Terms that cancel to zero are still sent. With either store empty a single zero term
// at exponent zero is sent with rsp_last set.
// Timing. With n1 and n2 terms loaded, the shared multiplier walks all n1*n2 pairs once to
// find the highest exponent, then once more per output term; each walk ends with the pipeline
// drain and the emit step. The single multiplier thus sets the length of a computation. A
// compute with an empty store goes straight to the emit step.
// req_ready is low for the whole computation. The result sits in an output register, so a
// stalled receiver only holds the sequencer at its emit step; the next item is taken as soon
// as the last term has been loaded into that register, whether or not it has been taken.
// Reset (synchronous, active high) empties both stores and clears the output valid flag.
`include "assert_macros.svh"

module sparse_polynomial_multiplier (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [spm_pkg::ACTION_W-1:0]              req_action,
   input  logic signed [spm_pkg::COEF_W-1:0]         req_coefficient,
   input  logic [spm_pkg::EXP_W-1:0]                 req_exponent,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [spm_pkg::PROD_COEF_W-1:0]    rsp_product_coefficient,
   output logic [spm_pkg::PROD_EXP_W-1:0]            rsp_product_exponent,
   output logic                                      rsp_last
);

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Term stores. Entries at or above the fill count are never used.
   logic signed [spm_pkg::COEF_W-1:0] first_coef_ff  [spm_pkg::MAX_TERMS_FIRST];
   logic [spm_pkg::EXP_W-1:0]         first_exp_ff   [spm_pkg::MAX_TERMS_FIRST];
   logic signed [spm_pkg::COEF_W-1:0] second_coef_ff [spm_pkg::MAX_TERMS_SECOND];
   logic [spm_pkg::EXP_W-1:0]         second_exp_ff  [spm_pkg::MAX_TERMS_SECOND];
   logic [spm_pkg::CNT1_W-1:0]        first_count_ff, first_count_in;
   logic [spm_pkg::CNT2_W-1:0]        second_count_ff, second_count_in;

   // Pair walk counters.
   logic [spm_pkg::IDX1_W-1:0] i_ff, i_in;
   logic [spm_pkg::IDX2_W-1:0] j_ff, j_in;

   // Product stage between the multiplier and the accumulator.
   logic                                   p_valid_ff, p_valid_in;
   logic signed [spm_pkg::MUL_W-1:0]       p_prod_ff, p_prod_in;
   logic [spm_pkg::PROD_EXP_W-1:0]         p_exp_ff, p_exp_in;

   // Scan state: the exponent being summed, its sum, and the highest exponent below it.
   logic [spm_pkg::THR_W-1:0]              thr_ff, thr_in;
   logic signed [spm_pkg::PROD_COEF_W-1:0] acc_ff, acc_in;
   logic                                   found_ff, found_in;
   logic [spm_pkg::PROD_EXP_W-1:0]         max_ff, max_in;

   // Output register.
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic signed [spm_pkg::PROD_COEF_W-1:0] rsp_coef_ff, rsp_coef_in;
   logic [spm_pkg::PROD_EXP_W-1:0]         rsp_exp_ff, rsp_exp_in;
   logic                                   rsp_last_ff, rsp_last_in;

   spm_pkg::action_type req_act;
   logic req_fire;
   logic emit_fire;
   logic last_pair;
   logic first_full, second_full;
   logic hit, below;

   assign req_act  = spm_pkg::action_type'(req_action);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign first_full  = (first_count_ff >= spm_pkg::CNT1_W'(spm_pkg::MAX_TERMS_FIRST));
   assign second_full = (second_count_ff >= spm_pkg::CNT2_W'(spm_pkg::MAX_TERMS_SECOND));

   assign last_pair =
      (spm_pkg::CNT1_W'(i_ff) == first_count_ff - spm_pkg::CNT1_W'(1)) &&
      (spm_pkg::CNT2_W'(j_ff) == second_count_ff - spm_pkg::CNT2_W'(1));

   // Shared multiplier and exponent adder, fed from the walk counters.
   always_comb begin
      p_prod_in = spm_pkg::MUL_W'(first_coef_ff[i_ff]) * spm_pkg::MUL_W'(second_coef_ff[j_ff]);
      p_exp_in  = {1'b0, first_exp_ff[i_ff]} + {1'b0, second_exp_ff[j_ff]};
   end

   assign hit   = p_valid_ff && (spm_pkg::THR_W'(p_exp_ff) == thr_ff);
   assign below = p_valid_ff && (spm_pkg::THR_W'(p_exp_ff) < thr_ff);

   // Store fill counts.
   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      if (req_fire) begin
         case (req_act)
            spm_pkg::ACT_LOAD_FIRST: begin
               if (!first_full) first_count_in = first_count_ff + spm_pkg::CNT1_W'(1);
            end
            spm_pkg::ACT_LOAD_SECOND: begin
               if (!second_full) second_count_in = second_count_ff + spm_pkg::CNT2_W'(1);
            end
            spm_pkg::ACT_CLEAR: begin
               first_count_in  = '0;
               second_count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer, accumulator and output register load.
   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      p_valid_in  = (state_ff == ST_SCAN);
      thr_in      = thr_ff;
      acc_in      = acc_ff;
      found_in    = found_ff;
      max_in      = max_ff;
      emit_fire   = 1'b0;
      rsp_coef_in = rsp_coef_ff;
      rsp_exp_in  = rsp_exp_ff;
      rsp_last_in = rsp_last_ff;

      // Second stage: sum the matching products, track the next exponent down.
      if (hit) acc_in = acc_ff + spm_pkg::PROD_COEF_W'(p_prod_ff);
      if (below && (!found_ff || p_exp_ff > max_ff)) begin
         found_in = 1'b1;
         max_in   = p_exp_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_act == spm_pkg::ACT_COMPUTE) begin
               i_in     = '0;
               j_in     = '0;
               acc_in   = '0;
               found_in = 1'b0;
               if (first_count_ff == '0 || second_count_ff == '0) begin
                  // Empty operand: a single zero term at exponent zero.
                  thr_in   = '0;
                  state_in = ST_EMIT;
               end else begin
                  thr_in   = spm_pkg::THR_ABOVE_ALL;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (last_pair) begin
               state_in = ST_DRAIN;
            end else if (spm_pkg::CNT2_W'(j_ff) == second_count_ff - spm_pkg::CNT2_W'(1)) begin
               j_in = '0;
               i_in = i_ff + spm_pkg::IDX1_W'(1);
            end else begin
               j_in = j_ff + spm_pkg::IDX2_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (thr_ff == spm_pkg::THR_ABOVE_ALL) begin
               // Opening walk only finds the top exponent; nothing to send yet.
               thr_in   = {1'b0, max_ff};
               acc_in   = '0;
               found_in = 1'b0;
               i_in     = '0;
               j_in     = '0;
               state_in = ST_SCAN;
            end else if (!rsp_valid_ff || rsp_ready) begin
               emit_fire   = 1'b1;
               rsp_coef_in = acc_ff;
               rsp_exp_in  = thr_ff[spm_pkg::PROD_EXP_W-1:0];
               rsp_last_in = !found_ff;
               if (found_ff) begin
                  thr_in   = {1'b0, max_ff};
                  acc_in   = '0;
                  found_in = 1'b0;
                  i_in     = '0;
                  j_in     = '0;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         p_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         found_ff        <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         p_valid_ff      <= p_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         found_ff        <= found_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      p_prod_ff   <= p_prod_in;
      p_exp_ff    <= p_exp_in;
      thr_ff      <= thr_in;
      acc_ff      <= acc_in;
      max_ff      <= max_in;
      rsp_coef_ff <= rsp_coef_in;
      rsp_exp_ff  <= rsp_exp_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Term stores, written at the fill count.
   always_ff @(posedge clock) begin
      if (req_fire && req_act == spm_pkg::ACT_LOAD_FIRST && !first_full) begin
         first_coef_ff[first_count_ff[spm_pkg::IDX1_W-1:0]] <= req_coefficient;
         first_exp_ff[first_count_ff[spm_pkg::IDX1_W-1:0]]  <=
            req_exponent & spm_pkg::EXP_KEEP_MASK;
      end
      if (req_fire && req_act == spm_pkg::ACT_LOAD_SECOND && !second_full) begin
         second_coef_ff[second_count_ff[spm_pkg::IDX2_W-1:0]] <= req_coefficient;
         second_exp_ff[second_count_ff[spm_pkg::IDX2_W-1:0]]  <=
            req_exponent & spm_pkg::EXP_KEEP_MASK;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_product_coefficient = rsp_coef_ff;
   assign rsp_product_exponent    = rsp_exp_ff;
   assign rsp_last                = rsp_last_ff;

   // The walk stays inside the filled part of both stores.
   `ASSERT_HOLDS(a_walk_in_range, clock, reset, (state_ff == ST_SCAN) |-> ((spm_pkg::CNT1_W'(i_ff) < first_count_ff) && (spm_pkg::CNT2_W'(j_ff) < second_count_ff)))
   // The next exponent found is always strictly below the one being summed.
   `ASSERT_HOLDS(a_next_below, clock, reset, found_ff |-> (spm_pkg::THR_W'(max_ff) < thr_ff))
   // A waiting result is never overwritten.
   `ASSERT_NEVER(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready && emit_fire)
   // Sending the final term of a run returns the sequencer to idle.
   `ASSERT_HOLDS(a_last_ends_run, clock, reset, (emit_fire && rsp_last_in) |=> (state_ff == ST_IDLE))
   // Stores do not change while a computation is running.
   `ASSERT_HOLDS(a_stores_stable, clock, reset, (state_ff != ST_IDLE) |=> ($stable(first_count_ff) && $stable(second_count_ff)))

endmodule
